>>> sv/crc16fc_pkg.sv
// shared constants, status codes and interface structs of the crc16 frame checker
package crc16fc_pkg;

    localparam int MAX_PAYLOAD   = 36;
    localparam int HEAD_LEN      = 9;
    localparam int TRAIL_LEN     = 4;
    localparam int MIN_FRAME     = 13;
    localparam int FRAME_MAX     = MIN_FRAME + MAX_PAYLOAD;
    localparam int CRC_START_POS = 6;
    localparam int POS_W         = $clog2(FRAME_MAX + 1);
    localparam int ADDR_W        = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int REQ_LEN_W     = 6;
    localparam int CFG_IDX_W     = 4;
    localparam int BIT_CNT_W     = 4;
    localparam int CNT_W         = 16;
    localparam int LEN_W         = 16;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [7:0]  HEAD0    = 8'hF9;
    localparam logic [7:0]  HEAD1    = 8'h26;
    localparam logic [7:0]  TAIL0    = 8'h62;
    localparam logic [7:0]  TAIL1    = 8'h9F;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_VERSION   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ID       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_COMMAND = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LENGTH  = 4'd3;

    typedef enum logic [2:0] {
        ST_OK,
        ST_HEAD,
        ST_LENGTH,
        ST_TAIL,
        ST_CRC,
        ST_NOT_REQ,
        ST_OVERSIZE
    } status_t;

    typedef struct packed {
        logic       clear;
        logic       start;
        logic [7:0] data;
    } crc_ctrl_t;

    typedef struct packed {
        logic        busy;
        logic        last_step;
        logic [15:0] value;
    } crc_stat_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } pbuf_req_t;

endpackage

>>> sv/crc16fc_crc_serial.sv
// bit-serial crc-16 update unit, one message bit per cycle
module crc16fc_crc_serial
    import crc16fc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  crc_ctrl_t ctrl,
    output crc_stat_t stat
);

    logic [15:0]          crc_reg;
    logic [15:0]          crc_next;
    logic [7:0]           data_reg;
    logic [7:0]           data_next;
    logic [BIT_CNT_W-1:0] cnt_reg;
    logic [BIT_CNT_W-1:0] cnt_next;
    logic                 feedback;
    logic [15:0]          shifted;

    always_comb
    begin
        feedback  = crc_reg[15] ^ data_reg[7];
        shifted   = {crc_reg[14:0], 1'b0} ^ (feedback ? CRC_POLY : 16'h0000);
        crc_next  = crc_reg;
        data_next = data_reg;
        cnt_next  = cnt_reg;
        if (ctrl.clear)
        begin
            crc_next = CRC_INIT;
            cnt_next = '0;
        end
        else if (ctrl.start)
        begin
            data_next = ctrl.data;
            cnt_next  = BIT_CNT_W'(8);
        end
        else if (cnt_reg != '0)
        begin
            crc_next  = shifted;
            data_next = {data_reg[6:0], 1'b0};
            cnt_next  = cnt_reg - BIT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_INIT;
            cnt_reg  <= '0;
            data_reg <= '0;
        end
        else
        begin
            crc_reg  <= crc_next;
            cnt_reg  <= cnt_next;
            data_reg <= data_next;
        end
    end

    assign stat.busy      = (cnt_reg != '0);
    assign stat.last_step = (cnt_reg == BIT_CNT_W'(1));
    assign stat.value     = crc_reg;

endmodule

>>> sv/crc16fc_payload_buf.sv
// payload byte store with one write port and a registered read port
module crc16fc_payload_buf
    import crc16fc_pkg::*;
(
    input  logic       clk,
    input  pbuf_req_t  req,
    output logic [7:0] rd_data
);

    logic [7:0] mem [MAX_PAYLOAD];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/crc16_frame_checker_core.sv
// top level of the crc16 frame checker: byte sequencer, verdict logic and counters
//
// usage: received bytes enter on the s_axis channel, one byte per transaction, with
// s_axis_tlast on the final byte of a buffer. each buffer is checked as one frame
// (head F9 26, header, little-endian length, payload, crc-16/ccitt-false, tail 62 9F).
// at the end of a buffer one verdict transaction leaves on m_axis (tuser 0); on an ok
// verdict the stored payload bytes follow (tuser 1), tlast on the final item.
// registers are written over the cfg channel (always ready), by the user only while
// the block is idle; the block itself does not enforce this. a byte at position 6
// up to the size limit is accepted, then stepped through the bit-serial crc unit,
// one step per bit; other bytes are only accepted. the last byte of a buffer passes
// S_EVAL before the verdict, each payload byte a store read and an output state.
// s_axis_tready is low while a byte or a buffer's results are in progress; a stalled
// m_axis receiver holds the current item and the block waits.
// reset clears position, crc, header, tail, counters and registers to their defaults;
// the payload store keeps no reset value.
module crc16_frame_checker_core
    import crc16fc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [7:0] rx_byte
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [2:0] status, [10:3] sequence_res, [18:11] command, [34:19] payload_length,
    // [42:35] payload_byte, [58:43] good_frames, [74:59] error_frames,
    // [90:75] crc_errors, [106:91] length_errors, [111:107] zero
    output logic [111:0]         m_axis_tdata,
    output logic                 m_axis_tuser,  // [0] item_kind
    output logic                 m_axis_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC,
        S_EVAL,
        S_VERDICT,
        S_PAY_RD,
        S_PAY_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [7:0]             header_reg [HEAD_LEN];
    logic [7:0]             header_next [HEAD_LEN];
    logic [7:0]             trailer_reg [TRAIL_LEN];
    logic [7:0]             trailer_next [TRAIL_LEN];
    logic                   oversize_reg, oversize_next;
    logic                   eob_reg, eob_next;
    logic [7:0]             version_reg, version_next;
    logic [7:0]             target_reg, target_next;
    logic [7:0]             command_reg, command_next;
    logic [REQ_LEN_W-1:0]   req_len_reg, req_len_next;
    logic [CNT_W-1:0]       good_reg, good_next;
    logic [CNT_W-1:0]       err_reg, err_next;
    logic [CNT_W-1:0]       crcerr_reg, crcerr_next;
    logic [CNT_W-1:0]       lenerr_reg, lenerr_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_kind_reg, out_kind_next;
    status_t                out_status_reg, out_status_next;
    logic [7:0]             out_seq_reg, out_seq_next;
    logic [7:0]             out_cmd_reg, out_cmd_next;
    logic [LEN_W-1:0]       out_len_reg, out_len_next;
    logic                   out_last_reg, out_last_next;
    logic [ADDR_W-1:0]      idx_reg, idx_next;

    crc_ctrl_t              crc_ctrl;
    crc_stat_t              crc_stat;
    pbuf_req_t              pbuf_req;
    logic [7:0]             pbuf_rd_data;

    logic                   in_fire;
    logic [LEN_W-1:0]       rx_len;
    logic [POS_W-1:0]       pay_off;
    logic [ADDR_W:0]        idx_plus;
    status_t                verdict;

    crc16fc_crc_serial u_crc (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (crc_ctrl),
        .stat (crc_stat)
    );

    crc16fc_payload_buf u_pbuf (
        .clk    (clk),
        .req    (pbuf_req),
        .rd_data(pbuf_rd_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign rx_len        = {header_reg[8], header_reg[7]};
    assign pay_off       = pos_reg - POS_W'(HEAD_LEN);
    assign idx_plus      = {1'b0, idx_reg} + {{ADDR_W{1'b0}}, 1'b1};

    // frame verdict from the collected header, tail and crc and the request registers
    always_comb
    begin
        if (oversize_reg)
        begin
            verdict = ST_OVERSIZE;
        end
        else if (pos_reg < POS_W'(MIN_FRAME) || header_reg[0] != HEAD0
                 || header_reg[1] != HEAD1)
        begin
            verdict = ST_HEAD;
        end
        else if (rx_len > LEN_W'(MAX_PAYLOAD)
                 || ({1'b0, rx_len} + (LEN_W+1)'(MIN_FRAME))
                    != (LEN_W+1)'(pos_reg))
        begin
            verdict = ST_LENGTH;
        end
        else if (trailer_reg[2] != TAIL0 || trailer_reg[3] != TAIL1)
        begin
            verdict = ST_TAIL;
        end
        else if ({trailer_reg[1], trailer_reg[0]} != crc_stat.value)
        begin
            verdict = ST_CRC;
        end
        else if (header_reg[2] != version_reg || header_reg[3] != target_reg
                 || header_reg[4] != command_reg
                 || rx_len != {{(LEN_W-REQ_LEN_W){1'b0}}, req_len_reg})
        begin
            verdict = ST_NOT_REQ;
        end
        else
        begin
            verdict = ST_OK;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        header_next     = header_reg;
        trailer_next    = trailer_reg;
        oversize_next   = oversize_reg;
        eob_next        = eob_reg;
        version_next    = version_reg;
        target_next     = target_reg;
        command_next    = command_reg;
        req_len_next    = req_len_reg;
        good_next       = good_reg;
        err_next        = err_reg;
        crcerr_next     = crcerr_reg;
        lenerr_next     = lenerr_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_seq_next    = out_seq_reg;
        out_cmd_next    = out_cmd_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        idx_next        = idx_reg;
        crc_ctrl        = '0;
        pbuf_req        = '0;
        pbuf_req.wr_addr = pay_off[ADDR_W-1:0];
        pbuf_req.wr_data = s_axis_tdata;
        pbuf_req.rd_addr = idx_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_VERSION:   version_next = cfg_data;
                REG_TARGET_ID:       target_next  = cfg_data;
                REG_REQUEST_COMMAND: command_next = cfg_data;
                REG_REQUEST_LENGTH:  req_len_next = cfg_data[REQ_LEN_W-1:0];
                default:             ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    eob_next   = s_axis_tlast;
                    state_next = s_axis_tlast ? S_EVAL : S_IDLE;
                    if (pos_reg >= POS_W'(FRAME_MAX))
                    begin
                        oversize_next = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < HEAD_LEN; i++)
                        begin
                            if (pos_reg == POS_W'(i))
                            begin
                                header_next[i] = s_axis_tdata;
                            end
                        end
                        pbuf_req.wr_en = (pos_reg >= POS_W'(HEAD_LEN))
                                         && (pay_off < POS_W'(MAX_PAYLOAD));
                        // oldest tail byte leaves the window into the crc
                        if (pos_reg >= POS_W'(CRC_START_POS))
                        begin
                            crc_ctrl.start = 1'b1;
                            crc_ctrl.data  = trailer_reg[0];
                            state_next     = S_CRC;
                        end
                        for (int i = 0; i < TRAIL_LEN - 1; i++)
                        begin
                            trailer_next[i] = trailer_reg[i+1];
                        end
                        trailer_next[TRAIL_LEN-1] = s_axis_tdata;
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
            end

            S_CRC:
            begin
                if (crc_stat.last_step)
                begin
                    state_next = eob_reg ? S_EVAL : S_IDLE;
                end
            end

            S_EVAL:
            begin
                out_status_next = verdict;
                out_kind_next   = 1'b0;
                out_valid_next  = 1'b1;
                idx_next        = '0;
                if (verdict == ST_OVERSIZE || verdict == ST_HEAD)
                begin
                    out_seq_next = '0;
                    out_cmd_next = '0;
                    out_len_next = '0;
                end
                else
                begin
                    out_seq_next = header_reg[6];
                    out_cmd_next = header_reg[4];
                    out_len_next = rx_len;
                end
                out_last_next = !(verdict == ST_OK && rx_len != '0);
                case (verdict)
                    ST_OK, ST_NOT_REQ:
                        good_next = good_reg + CNT_W'(1);
                    ST_LENGTH:
                    begin
                        err_next    = err_reg + CNT_W'(1);
                        lenerr_next = lenerr_reg + CNT_W'(1);
                    end
                    ST_CRC:
                    begin
                        err_next    = err_reg + CNT_W'(1);
                        crcerr_next = crcerr_reg + CNT_W'(1);
                    end
                    default:
                        err_next = err_reg + CNT_W'(1);
                endcase
                // buffer state returns to its start values, payload store stays
                pos_next       = '0;
                oversize_next  = 1'b0;
                crc_ctrl.clear = 1'b1;
                for (int i = 0; i < HEAD_LEN; i++)
                begin
                    header_next[i] = '0;
                end
                for (int i = 0; i < TRAIL_LEN; i++)
                begin
                    trailer_next[i] = '0;
                end
                state_next = S_VERDICT;
            end

            S_VERDICT:
            begin
                if (m_axis_tready)
                begin
                    out_valid_next = 1'b0;
                    state_next = (out_status_reg == ST_OK && !out_last_reg) ? S_PAY_RD
                                                                            : S_IDLE;
                end
            end

            S_PAY_RD:
            begin
                pbuf_req.rd_en = 1'b1;
                out_kind_next  = 1'b1;
                out_last_next  = (idx_plus == out_len_reg[ADDR_W:0]);
                out_valid_next = 1'b1;
                state_next     = S_PAY_OUT;
            end

            S_PAY_OUT:
            begin
                if (m_axis_tready)
                begin
                    out_valid_next = 1'b0;
                    idx_next       = idx_plus[ADDR_W-1:0];
                    state_next     = out_last_reg ? S_IDLE : S_PAY_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            oversize_reg  <= 1'b0;
            eob_reg       <= 1'b0;
            version_reg   <= 8'd1;
            target_reg    <= 8'd0;
            command_reg   <= 8'd0;
            req_len_reg   <= REQ_LEN_W'(28);
            good_reg      <= '0;
            err_reg       <= '0;
            crcerr_reg    <= '0;
            lenerr_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
            idx_reg       <= '0;
            for (int i = 0; i < HEAD_LEN; i++)
            begin
                header_reg[i] <= '0;
            end
            for (int i = 0; i < TRAIL_LEN; i++)
            begin
                trailer_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            header_reg    <= header_next;
            trailer_reg   <= trailer_next;
            oversize_reg  <= oversize_next;
            eob_reg       <= eob_next;
            version_reg   <= version_next;
            target_reg    <= target_next;
            command_reg   <= command_next;
            req_len_reg   <= req_len_next;
            good_reg      <= good_next;
            err_reg       <= err_next;
            crcerr_reg    <= crcerr_next;
            lenerr_reg    <= lenerr_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_last_reg  <= out_last_next;
            idx_reg       <= idx_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_seq_reg    <= out_seq_next;
        out_cmd_reg    <= out_cmd_next;
        out_len_reg    <= out_len_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {5'b00000, lenerr_reg, crcerr_reg, err_reg, good_reg,
                            (out_kind_reg ? pbuf_rd_data : 8'h00),
                            out_len_reg, out_cmd_reg, out_seq_reg, out_status_reg};

`ifndef SYNTHESIS
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        crc_stat.busy |-> !s_axis_tready)
        else $error("input ready while crc unit is busy");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a result is pending");

    a_reject_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser && m_axis_tdata[2:0] != ST_OK) |-> m_axis_tlast)
        else $error("rejected verdict not marked last");

    a_payload_after_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (out_status_reg == ST_OK))
        else $error("payload item for a frame that is not ok");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("result shown after the final item of a buffer");
`endif

endmodule

>>> sim/tb_crc16_frame_checker_core.sv
// self-checking testbench for crc16_frame_checker_core: frame stimulus, verdict prediction, checks
package frame_check_pkg;

    import crc16fc_pkg::*;

    typedef struct {
        bit        kind;
        status_t   status;
        bit [7:0]  seq;
        bit [7:0]  cmd;
        bit [15:0] len;
        bit [7:0]  pbyte;
        bit        last;
        bit [15:0] good;
        bit [15:0] errs;
        bit [15:0] crc_errs;
        bit [15:0] len_errs;
    } rx_item_t;

    // crc-16/ccitt-false, msb first, one byte
    function automatic bit [15:0] crc_next(bit [15:0] c, bit [7:0] b);
        int k;
        c = c ^ {b, 8'h00};
        for (k = 0; k < 8; k++)
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    class verdict_tracker;
        bit [7:0]  want_version;
        bit [7:0]  want_target;
        bit [7:0]  want_command;
        bit [5:0]  want_length;
        int        fill;
        bit [15:0] crc_acc;
        bit [7:0]  head [HEAD_LEN];
        bit [7:0]  tail [TRAIL_LEN];
        bit [7:0]  payload [MAX_PAYLOAD];
        bit        overrun;
        bit [15:0] n_good;
        bit [15:0] n_err;
        bit [15:0] n_crc;
        bit [15:0] n_len;
        rx_item_t  due_results [$];
        int        mismatches;
        int        checked;
        int        verdicts;
        int        status_hits [7];

        function new();
            want_version = 8'd1;
            want_target  = 8'd0;
            want_command = 8'd0;
            want_length  = 6'd28;
            n_good = 0;
            n_err  = 0;
            n_crc  = 0;
            n_len  = 0;
            mismatches = 0;
            checked = 0;
            verdicts = 0;
            foreach (status_hits[k])
                status_hits[k] = 0;
            restart();
        endfunction

        function void restart();
            fill    = 0;
            crc_acc = CRC_INIT;
            overrun = 1'b0;
            foreach (head[k])
                head[k] = 8'h00;
            foreach (tail[k])
                tail[k] = 8'h00;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [7:0] val);
            case (idx)
                REG_FRAME_VERSION:   want_version = val;
                REG_TARGET_ID:       want_target  = val;
                REG_REQUEST_COMMAND: want_command = val;
                REG_REQUEST_LENGTH:  want_length  = val[REQ_LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void queue_result(bit kind, status_t st, bit [7:0] seq, bit [7:0] cmd,
                                   bit [15:0] len, bit [7:0] pb, bit last);
            rx_item_t r;
            r.kind = kind;
            r.status = st;
            r.seq = seq;
            r.cmd = cmd;
            r.len = len;
            r.pbyte = pb;
            r.last = last;
            r.good = n_good;
            r.errs = n_err;
            r.crc_errs = n_crc;
            r.len_errs = n_len;
            due_results.push_back(r);
        endfunction

        // one accepted byte; at the end of a buffer this queues the verdict and payload
        function void take_byte(bit [7:0] b, bit eob);
            bit [15:0] len;
            status_t   verdict;
            int        k;
            if (fill >= FRAME_MAX)
                overrun = 1'b1;
            else
            begin
                if (fill < HEAD_LEN)
                    head[fill] = b;
                else if (fill - HEAD_LEN < MAX_PAYLOAD)
                    payload[fill - HEAD_LEN] = b;
                // crc trails the input by the four bytes held in the tail window
                if (fill >= CRC_START_POS)
                    crc_acc = crc_next(crc_acc, tail[0]);
                tail[0] = tail[1];
                tail[1] = tail[2];
                tail[2] = tail[3];
                tail[3] = b;
                fill++;
            end
            if (!eob)
                return;
            verdicts++;
            len = {head[8], head[7]};
            if (overrun)
            begin
                n_err++;
                verdict = ST_OVERSIZE;
            end
            else if (fill < MIN_FRAME || head[0] != HEAD0 || head[1] != HEAD1)
            begin
                n_err++;
                verdict = ST_HEAD;
            end
            else if (len > MAX_PAYLOAD || MIN_FRAME + len != fill)
            begin
                n_err++;
                n_len++;
                verdict = ST_LENGTH;
            end
            else if (tail[2] != TAIL0 || tail[3] != TAIL1)
            begin
                n_err++;
                verdict = ST_TAIL;
            end
            else if ({tail[1], tail[0]} != crc_acc)
            begin
                n_err++;
                n_crc++;
                verdict = ST_CRC;
            end
            else
            begin
                n_good++;
                if (head[2] != want_version || head[3] != want_target ||
                    head[4] != want_command || len != want_length)
                    verdict = ST_NOT_REQ;
                else
                    verdict = ST_OK;
            end
            status_hits[verdict]++;
            if (verdict == ST_OVERSIZE || verdict == ST_HEAD)
                queue_result(1'b0, verdict, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b1);
            else
            begin
                queue_result(1'b0, verdict, head[6], head[4], len, 8'h00,
                             verdict != ST_OK || len == 0);
                if (verdict == ST_OK)
                    for (k = 0; k < len; k++)
                        queue_result(1'b1, ST_OK, head[6], head[4], len, payload[k],
                                     k + 1 == len);
            end
            restart();
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        task check_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                flag_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                        checked, name, got, want));
        endtask

        task check_item(rx_item_t got);
            rx_item_t want;
            if (due_results.size() == 0)
            begin
                flag_mismatch($sformatf("result with nothing pending (kind %0d status %0d)",
                                        got.kind, got.status));
                return;
            end
            want = due_results.pop_front();
            check_field("item_kind", got.kind, want.kind);
            check_field("status", got.status, want.status);
            check_field("sequence", got.seq, want.seq);
            check_field("command", got.cmd, want.cmd);
            check_field("payload_length", got.len, want.len);
            check_field("payload_byte", got.pbyte, want.pbyte);
            check_field("last", got.last, want.last);
            check_field("good_frames", got.good, want.good);
            check_field("error_frames", got.errs, want.errs);
            check_field("crc_errors", got.crc_errs, want.crc_errs);
            check_field("length_errors", got.len_errs, want.len_errs);
            checked++;
        endtask
    endclass

endpackage

module tb_crc16_frame_checker_core;

    timeunit 1ns;
    timeprecision 1ps;

    import crc16fc_pkg::*;
    import frame_check_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd15;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 24;

    typedef enum {
        FLAW_NONE,
        FLAW_HEAD0,
        FLAW_HEAD1,
        FLAW_TAIL0,
        FLAW_TAIL1,
        FLAW_CRC,
        FLAW_TRUNC
    } flaw_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [111:0]         m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    verdict_tracker sb = new();
    rx_item_t       seen;
    bit [7:0]       tx_bytes [$];
    bit             src_idle_on;
    bit             sink_idle_on;
    bit             hold_off_req;
    int             src_calm;
    int             bytes_sent;
    int             buffers_sent;
    int             settings_loaded;

    crc16_frame_checker_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("** crc16_frame_checker_core: FAILED **");
        $finish;
    end

    // result side: take each transaction and compare it with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            seen.kind     = m_axis_tuser;
            seen.status   = status_t'(m_axis_tdata[2:0]);
            seen.seq      = m_axis_tdata[10:3];
            seen.cmd      = m_axis_tdata[18:11];
            seen.len      = m_axis_tdata[34:19];
            seen.pbyte    = m_axis_tdata[42:35];
            seen.last     = m_axis_tlast;
            seen.good     = m_axis_tdata[58:43];
            seen.errs     = m_axis_tdata[74:59];
            seen.crc_errs = m_axis_tdata[90:75];
            seen.len_errs = m_axis_tdata[106:91];
            sb.check_item(seen);
        end
    end

    // receiver pacing, plus one long hold-off on request once a result is waiting
    initial
    begin : sink_pacing
        int calm;
        calm = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                do
                    @(posedge clk);
                while (m_axis_tvalid !== 1'b1);
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
                hold_off_req = 1'b0;
            end
            else if (calm > 0)
            begin
                calm--;
                m_axis_tready <= 1'b1;
            end
            else if (sink_idle_on && $urandom_range(0, 63) == 0)
                calm = $urandom_range(30, 120);
            else if (sink_idle_on && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic void build_frame(bit [7:0] ver, bit [7:0] tgt, bit [7:0] cmd,
                                        bit [15:0] len_field, int npay, flaw_t flaw);
        bit [15:0] c;
        int        k;
        tx_bytes = {};
        tx_bytes.push_back(HEAD0);
        tx_bytes.push_back(HEAD1);
        tx_bytes.push_back(ver);
        tx_bytes.push_back(tgt);
        tx_bytes.push_back(cmd);
        tx_bytes.push_back(8'($urandom));
        tx_bytes.push_back(8'($urandom));
        tx_bytes.push_back(len_field[7:0]);
        tx_bytes.push_back(len_field[15:8]);
        for (k = 0; k < npay; k++)
            tx_bytes.push_back(8'($urandom));
        c = CRC_INIT;
        for (k = 2; k < tx_bytes.size(); k++)
            c = crc_next(c, tx_bytes[k]);
        tx_bytes.push_back(c[7:0]);
        tx_bytes.push_back(c[15:8]);
        tx_bytes.push_back(TAIL0);
        tx_bytes.push_back(TAIL1);
        case (flaw)
            FLAW_HEAD0: tx_bytes[0] ^= 8'h01 << $urandom_range(0, 7);
            FLAW_HEAD1: tx_bytes[1] ^= 8'h01 << $urandom_range(0, 7);
            FLAW_TAIL0: tx_bytes[tx_bytes.size() - 2] ^= 8'h01 << $urandom_range(0, 7);
            FLAW_TAIL1: tx_bytes[tx_bytes.size() - 1] ^= 8'h01 << $urandom_range(0, 7);
            FLAW_CRC:
                tx_bytes[tx_bytes.size() - 4 + $urandom_range(0, 1)] ^=
                    8'h01 << $urandom_range(0, 7);
            FLAW_TRUNC:
                repeat ($urandom_range(1, 6)) void'(tx_bytes.pop_back());
            default: ;
        endcase
    endfunction

    function automatic void fill_noise(int n, bit good_head);
        int k;
        tx_bytes = {};
        for (k = 0; k < n; k++)
            tx_bytes.push_back(8'($urandom));
        if (good_head && n >= 2)
        begin
            tx_bytes[0] = HEAD0;
            tx_bytes[1] = HEAD1;
        end
    endfunction

    // well-formed frames in just over half the picks, most for the current settings, the rest broken or noise
    function automatic void make_random_buffer();
        int       pick;
        int       npay;
        bit [7:0] v;
        bit [7:0] t;
        bit [7:0] c;
        pick = $urandom_range(0, 99);
        v = sb.want_version;
        t = sb.want_target;
        c = sb.want_command;
        if (pick < 45 && sb.want_length <= MAX_PAYLOAD)
            npay = sb.want_length;
        else
            npay = ($urandom_range(0, 15) == 0) ? MAX_PAYLOAD : $urandom_range(0, 6);
        if (pick < 45)
            build_frame(v, t, c, 16'(npay), npay, FLAW_NONE);
        else if (pick < 55)
        begin
            case ($urandom_range(0, 3))
                0: v ^= 8'($urandom_range(1, 255));
                1: t ^= 8'($urandom_range(1, 255));
                2: c ^= 8'($urandom_range(1, 255));
                default: ;
            endcase
            build_frame(v, t, c, 16'(npay), npay, FLAW_NONE);
        end
        else if (pick < 62)
            build_frame(v, t, c, 16'(npay), npay, FLAW_CRC);
        else if (pick < 68)
            build_frame(v, t, c, 16'(npay), npay,
                        ($urandom_range(0, 1) == 0) ? FLAW_TAIL0 : FLAW_TAIL1);
        else if (pick < 74)
            build_frame(v, t, c,
                        ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'(npay + $urandom_range(1, 3)),
                        npay, FLAW_NONE);
        else if (pick < 80)
            build_frame(v, t, c, 16'(npay), npay,
                        ($urandom_range(0, 1) == 0) ? FLAW_HEAD0 : FLAW_HEAD1);
        else if (pick < 86)
            build_frame(v, t, c, 16'(npay), npay, FLAW_TRUNC);
        else if (pick < 94)
            fill_noise($urandom_range(1, 30), 1'($urandom_range(0, 1)));
        else
            fill_noise($urandom_range(FRAME_MAX + 1, FRAME_MAX + 12), 1'b1);
    endfunction

    task automatic send_byte(input bit [7:0] b, input bit eob);
        if (src_calm > 0)
            src_calm--;
        else if (src_idle_on && $urandom_range(0, 47) == 0)
            src_calm = $urandom_range(20, 80);
        else if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eob;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        sb.take_byte(b, eob);
        bytes_sent++;
    endtask

    task automatic send_buffer();
        int k;
        for (k = 0; k < tx_bytes.size(); k++)
            send_byte(tx_bytes[k], k == tx_bytes.size() - 1);
        buffers_sent++;
    endtask

    // wait for every predicted result, then let any byte still in work finish
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input bit [7:0] ver, input bit [7:0] tgt, input bit [7:0] cmd,
                                 input bit [7:0] len_val, input bit poke_spare);
        logic [CFG_IDX_W-1:0] idx [5];
        bit [7:0]             val [5];
        int                   k;
        idx = '{REG_SPARE, REG_FRAME_VERSION, REG_TARGET_ID, REG_REQUEST_COMMAND,
                REG_REQUEST_LENGTH};
        val = '{8'($urandom), ver, tgt, cmd, len_val};
        for (k = poke_spare ? 0 : 1; k < 5; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do
                @(posedge clk);
            while (cfg_ready !== 1'b1);
            sb.set_reg(idx[k], val[k]);
        end
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    task automatic random_phase(input int byte_budget, input int min_verdicts);
        int first_byte;
        int first_verdict;
        first_byte    = bytes_sent;
        first_verdict = sb.verdicts;
        while (bytes_sent - first_byte < byte_budget ||
               sb.verdicts - first_verdict < min_verdicts)
        begin
            make_random_buffer();
            send_buffer();
        end
        drain();
    endtask

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_FRAME_VERSION;
        cfg_data      <= 8'h00;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        hold_off_req  = 1'b0;
        src_calm      = 0;
        bytes_sent    = 0;
        buffers_sent  = 0;
        settings_loaded = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // the first verdict is held back by the receiver, which stalls the following buffers
        hold_off_req = 1'b1;
        // reset settings: version 1, target 0, command 0, length 28
        build_frame(8'd1, 8'd0, 8'd0, 16'd28, 28, FLAW_NONE);
        send_buffer();
        fill_noise(1, 1'b0);
        send_buffer();
        // one byte short of a minimal frame
        build_frame(8'd1, 8'd0, 8'd0, 16'd0, 0, FLAW_NONE);
        void'(tx_bytes.pop_back());
        send_buffer();
        build_frame(8'd1, 8'd0, 8'd0, 16'd0, 0, FLAW_HEAD0);
        send_buffer();
        build_frame(8'd1, 8'd0, 8'd0, 16'd0, 0, FLAW_HEAD1);
        send_buffer();
        build_frame(8'd1, 8'd0, 8'd0, 16'd3, 2, FLAW_NONE);
        send_buffer();
        build_frame(8'd1, 8'd0, 8'd0, 16'hFFFF, 0, FLAW_NONE);
        send_buffer();
        build_frame(8'd1, 8'd0, 8'd0, 16'd0, 0, FLAW_TAIL0);
        send_buffer();
        build_frame(8'd1, 8'd0, 8'd0, 16'd0, 0, FLAW_TAIL1);
        send_buffer();
        build_frame(8'd1, 8'd0, 8'd0, 16'd0, 0, FLAW_CRC);
        send_buffer();
        build_frame(8'd2, 8'd0, 8'd0, 16'd28, 28, FLAW_NONE);
        send_buffer();
        // exactly one byte past the largest frame
        fill_noise(FRAME_MAX + 1, 1'b1);
        send_buffer();
        drain();

        load_settings(8'hFF, 8'hFF, 8'hFF, 8'd0, 1'b1);
        build_frame(8'hFF, 8'hFF, 8'hFF, 16'd0, 0, FLAW_NONE);
        send_buffer();
        build_frame(8'hFF, 8'hFF, 8'h00, 16'd0, 0, FLAW_NONE);
        send_buffer();
        build_frame(8'hFF, 8'hFE, 8'hFF, 16'd0, 0, FLAW_NONE);
        send_buffer();
        drain();

        load_settings(8'h00, 8'h00, 8'h00, 8'(MAX_PAYLOAD), 1'b0);
        build_frame(8'h00, 8'h00, 8'h00, 16'(MAX_PAYLOAD), MAX_PAYLOAD, FLAW_NONE);
        send_buffer();
        drain();

        // only the low six bits of the length register are kept
        load_settings(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1);
        build_frame(8'h00, 8'h00, 8'h00, 16'd0, 0, FLAW_NONE);
        send_buffer();
        build_frame(8'h00, 8'h00, 8'h00, 16'd63, 0, FLAW_NONE);
        send_buffer();
        drain();

        load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(1, 6)), 1'b0);
        random_phase(10, 0);
        load_settings(8'h00, 8'h00, 8'h00, 8'd0, 1'b0);
        random_phase(10, 0);
        load_settings(8'hFF, 8'hFF, 8'hFF, 8'(MAX_PAYLOAD), 1'b1);
        random_phase(10, 0);

        // closing stretch with both sides always ready
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(0, 8)), 1'b0);
        random_phase(30, 0);

        $display("run: %0d buffers, %0d bytes, %0d results checked, %0d register loads",
                 buffers_sent, bytes_sent, sb.checked, settings_loaded);
        $display("verdicts: ok %0d, head %0d, length %0d, tail %0d, crc %0d, not req %0d, over %0d",
                 sb.status_hits[ST_OK], sb.status_hits[ST_HEAD], sb.status_hits[ST_LENGTH],
                 sb.status_hits[ST_TAIL], sb.status_hits[ST_CRC], sb.status_hits[ST_NOT_REQ],
                 sb.status_hits[ST_OVERSIZE]);
        if (sb.mismatches == 0 && sb.due_results.size() == 0)
            $display("** crc16_frame_checker_core: PASSED **");
        else
            $display("** crc16_frame_checker_core: FAILED **");
        $finish;
    end

endmodule
